// File: design/cdpd_pkg.sv
// types and constants shared by the cam duty pattern detector files
package cdpd_pkg;

    localparam int RING_DEPTH = 8;
    localparam int DIV_STEPS  = 31;
    localparam int BOUND_W    = 56;
    localparam int CFG_IDX_W  = 2;

    localparam logic [6:0] DUTY_FULL  = 7'd100;
    localparam logic [2:0] CODE_NONE  = 3'd4;
    localparam logic [2:0] MIN_PULSES = 3'd4;
    localparam logic [2:0] PC_RESET   = 3'd4;

    localparam logic [CFG_IDX_W-1:0] REG_PULSE_COUNT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_DUTY_LOW    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_DUTY_HIGH   = 2'd2;

    typedef struct packed {
        logic [23:0] pulse_period;
        logic [23:0] off_period;
    } t_in_req;

    typedef struct packed {
        logic [6:0] duty_percent;
        logic [2:0] cylinder_code;
    } t_out_req;

    typedef logic [6:0] t_duty;

endpackage

// File: design/cam_duty_pattern_detector_core.sv
// cam duty pattern detector: bit-serial duty divider and serial window search
// a request passes through the divider steps, one ring update, one to four window starts
// and one output load before its result is valid; the divider gives one bit per cycle
// a new request is taken only in idle, after the previous result has been loaded
// a finished result waits in the output register while the next request is taken
// reset: synchronous active low, clears control, duty ring and config registers
module cam_duty_pattern_detector_core (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_in_valid,
    output logic                             o_in_stall,
    input  cdpd_pkg::t_in_req                i_in_data,
    output logic                             o_out_valid,
    input  logic                             i_out_stall,
    output cdpd_pkg::t_out_req               o_out_data,
    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic [cdpd_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [cdpd_pkg::BOUND_W-1:0]     i_cfg_data
);
    import cdpd_pkg::*;

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_DIV  = 3'd1;
    localparam logic [2:0] ST_FIN  = 3'd2;
    localparam logic [2:0] ST_SRCH = 3'd3;
    localparam logic [2:0] ST_DONE = 3'd4;

    logic [2:0]         r_state;
    logic [2:0]         r_pc;
    logic [BOUND_W-1:0] r_dlo;
    logic [BOUND_W-1:0] r_dhi;
    t_duty              r_ring [RING_DEPTH];
    t_duty              r_scan [RING_DEPTH];
    logic [30:0]        r_num;
    logic [23:0]        r_per;
    logic [23:0]        r_rem;
    logic [6:0]         r_quo;
    logic               r_ovf;
    logic [4:0]         r_cnt;
    logic [1:0]         r_start;
    t_duty              r_duty;
    logic               r_out_valid;
    t_out_req           r_out;
    logic [2:0]         r_code;

    logic [24:0] rem_sh;
    logic [24:0] rem_diff;
    logic        rem_ge;
    t_duty       n_duty;
    logic [2:0]  pc_eff;
    logic [1:0]  start_last;
    logic        win_ok;
    logic        in_take;

    assign o_cfg_ready = 1'b1;
    assign o_in_stall  = (r_state != ST_IDLE);
    assign in_take     = i_in_valid && (r_state == ST_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    assign rem_sh   = {r_rem, r_num[30]};
    assign rem_diff = rem_sh - {1'b0, r_per};
    assign rem_ge   = (rem_sh >= {1'b0, r_per});

    always_comb begin
        if (r_per == '0) begin
            n_duty = '0;
        end else if (r_ovf || (r_quo > DUTY_FULL)) begin
            n_duty = DUTY_FULL;
        end else begin
            n_duty = r_quo;
        end
    end

    assign pc_eff     = (r_pc < MIN_PULSES) ? MIN_PULSES : r_pc;
    assign start_last = 2'(3'd7 - pc_eff);

    always_comb begin
        win_ok = 1'b1;
        for (int k = 0; k < RING_DEPTH - 1; k++) begin
            if (3'(k) < pc_eff) begin
                if (({1'b0, r_scan[k]} < r_dlo[8*k +: 8]) ||
                    ({1'b0, r_scan[k]} > r_dhi[8*k +: 8])) begin
                    win_ok = 1'b0;
                end
            end
        end
    end

    // config registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc  <= PC_RESET;
            r_dlo <= '0;
            r_dhi <= '0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                REG_PULSE_COUNT: r_pc  <= i_cfg_data[2:0];
                REG_DUTY_LOW:    r_dlo <= i_cfg_data;
                REG_DUTY_HIGH:   r_dhi <= i_cfg_data;
                default:         ;
            endcase
        end
    end

    // control and duty ring
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
            r_cnt       <= '0;
            r_start     <= '0;
            for (int i = 0; i < RING_DEPTH; i++) begin
                r_ring[i] <= '0;
            end
        end else begin
            if ((r_state == ST_DONE) && (!r_out_valid || !i_out_stall)) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                ST_IDLE: begin
                    if (in_take) begin
                        r_cnt   <= '0;
                        r_state <= ST_DIV;
                    end
                end
                ST_DIV: begin
                    r_cnt <= r_cnt + 5'd1;
                    if (r_cnt == 5'(DIV_STEPS - 1)) begin
                        r_state <= ST_FIN;
                    end
                end
                ST_FIN: begin
                    for (int i = 0; i < RING_DEPTH - 1; i++) begin
                        r_ring[i] <= r_ring[i+1];
                    end
                    r_ring[RING_DEPTH-1] <= n_duty;
                    r_start <= '0;
                    r_state <= ST_SRCH;
                end
                ST_SRCH: begin
                    if (win_ok || (r_start == start_last)) begin
                        r_state <= ST_DONE;
                    end else begin
                        r_start <= r_start + 2'd1;
                    end
                end
                ST_DONE: begin
                    if (!r_out_valid || !i_out_stall) begin
                        r_state <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    // divider and search datapath
    always_ff @(posedge i_clk) begin
        case (r_state)
            ST_IDLE: begin
                if (in_take) begin
                    r_num <= 31'(i_in_data.off_period) * 31'(DUTY_FULL);
                    r_per <= i_in_data.pulse_period;
                    r_rem <= '0;
                    r_quo <= '0;
                    r_ovf <= 1'b0;
                end
            end
            ST_DIV: begin
                r_num <= {r_num[29:0], 1'b0};
                r_rem <= rem_ge ? rem_diff[23:0] : rem_sh[23:0];
                r_quo <= {r_quo[5:0], rem_ge};
                r_ovf <= r_ovf | r_quo[6];
            end
            ST_FIN: begin
                r_duty <= n_duty;
                for (int i = 0; i < RING_DEPTH - 1; i++) begin
                    r_scan[i] <= r_ring[i+1];
                end
                r_scan[RING_DEPTH-1] <= n_duty;
            end
            ST_SRCH: begin
                if (win_ok) begin
                    r_code <= 3'(2'd3 - r_start);
                end else if (r_start == start_last) begin
                    r_code <= CODE_NONE;
                end else begin
                    for (int i = 0; i < RING_DEPTH - 1; i++) begin
                        r_scan[i] <= r_scan[i+1];
                    end
                end
            end
            ST_DONE: begin
                if (!r_out_valid || !i_out_stall) begin
                    r_out.duty_percent  <= r_duty;
                    r_out.cylinder_code <= r_code;
                end
            end
            default: ;
        endcase
    end

endmodule

// File: design/cdpd_checker.sv
// port-level checker for the cam duty pattern detector and its bind
module cdpd_checker (
    input logic                             i_clk,
    input logic                             i_rst_n,
    input logic                             i_in_valid,
    input logic                             o_in_stall,
    input logic                             o_out_valid,
    input logic                             i_out_stall,
    input cdpd_pkg::t_out_req               o_out_data
);
    import cdpd_pkg::*;

    a_duty_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_data.duty_percent <= DUTY_FULL))
        else $error("duty above full scale");

    a_code_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_data.cylinder_code <= CODE_NONE))
        else $error("cylinder code out of range");

    a_busy_after_req: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("input taken again while busy");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> (o_out_valid && $stable(o_out_data)))
        else $error("stalled result dropped or changed");

    a_reset_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

endmodule

bind cam_duty_pattern_detector_core cdpd_checker u_cdpd_checker (.*);
